// File: design/swm_pkg.sv
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       seq_last;
  } swm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_max;
    logic                       max_last;
  } swm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } swm_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic check;
    logic scan_step;
    logic emit;
  } swm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic produce;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } swm_sts_t;

endpackage

// File: design/swm_ctrl.sv
module swm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  swm_pkg::swm_sts_t sts_i,
  output logic             in_stall_o,
  output swm_pkg::swm_cmd_t cmd_o
);
  import swm_pkg::*;

  swm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        priority if (sts_i.need_scan) begin
          state_d = ST_SCAN;
        end else if (sts_i.produce) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/swm_dp.sv
module swm_dp #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  swm_pkg::swm_in_t           in_data_i,
  input  swm_pkg::swm_cmd_t          cmd_i,
  output swm_pkg::swm_sts_t          sts_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output swm_pkg::swm_out_t          out_data_o
);
  import swm_pkg::*;

  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int RST_K  = (WINDOW_MAX < 3) ? WINDOW_MAX : 3;

  logic signed [SAMPLE_W-1:0] mem_q [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic signed [SAMPLE_W-1:0] cur_q;
  logic                       last_q;
  logic [CNT_W-1:0]           k_q;
  logic [ADDR_W-1:0]          wp_q;
  logic [CNT_W-1:0]           fill_q;
  logic                       full_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       out_valid_q;
  swm_out_t                   out_q;

  logic [CNT_W-1:0]  cfg_k;
  logic [ADDR_W-1:0] wp_eff;
  logic [CNT_W-1:0]  wp_inc;
  logic [ADDR_W-1:0] wp_nxt;
  logic [CNT_W-1:0]  fill_inc;
  logic              fill_hit;
  logic              fast;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // saturate the window size to one .. WINDOW_MAX
  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      cfg_k = CNT_W'(1);
    end else if (int'(cfg_wdata_i) > WINDOW_MAX) begin
      cfg_k = CNT_W'(WINDOW_MAX);
    end else begin
      cfg_k = CNT_W'(cfg_wdata_i);
    end
  end

  assign wp_eff   = (CNT_W'(wp_q) < k_q) ? wp_q : '0;
  assign wp_inc   = CNT_W'(wp_eff) + CNT_W'(1);
  assign wp_nxt   = (wp_inc >= k_q) ? '0 : wp_inc[ADDR_W-1:0];
  assign fill_inc = fill_q + CNT_W'(1);
  assign fill_hit = (fill_inc >= k_q);
  assign fast     = (rdata_q < cur_q);

  assign sts_o.produce   = full_q | fill_hit;
  assign sts_o.need_scan = full_q ? !fast : fill_hit;
  assign sts_o.scan_done = (cnt_q == k_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign rd_en   = cmd_i.accept || (cmd_i.scan_step && (cnt_q < k_q));
  assign rd_addr = cmd_i.accept ? wp_eff : cnt_q[ADDR_W-1:0];

  // window ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      mem_q[wp_eff] <= smp_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q  <= in_data_i.sample;
      last_q <= in_data_i.seq_last;
    end
    if (cmd_i.emit) begin
      out_q.window_max <= cur_q;
      out_q.max_last   <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= CNT_W'(RST_K);
      wp_q        <= '0;
      fill_q      <= '0;
      full_q      <= 1'b0;
      cur_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q    <= cfg_k;
        wp_q   <= '0;
        fill_q <= '0;
        full_q <= 1'b0;
      end
      if (cmd_i.check) begin
        cnt_q <= '0;
        if (last_q) begin
          wp_q   <= '0;
          fill_q <= '0;
          full_q <= 1'b0;
        end else begin
          wp_q <= wp_nxt;
          if (!full_q) begin
            fill_q <= fill_hit ? k_q : fill_inc;
            full_q <= fill_hit;
          end
        end
        if (full_q && fast && (smp_q > cur_q)) begin
          cur_q <= smp_q;
        end
      end
      if (cmd_i.scan_step) begin
        if (cnt_q != k_q) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (cnt_q != '0) begin
          if ((cnt_q == CNT_W'(1)) || (rdata_q > cur_q)) begin
            cur_q <= rdata_q;
          end
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/sliding_window_max.sv
// Running maximum over the last window_size signed samples (1 to WINDOW_MAX; zero acts as one,
// larger values saturate). No result comes out until the window first fills, then one maximum
// per sample, tagged with the sample's seq_last; a beat with seq_last set empties the window, as
// does a write of window_size. One sample is in work at a time: after the check state it is
// done if it gives no result, is emitted if the leaving sample is below the running maximum,
// and else the window is first scanned to rebuild the maximum, one stored sample per cycle over
// the single read port. A finished result waits in the output register without holding up input.
module sliding_window_max #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  swm_pkg::swm_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output swm_pkg::swm_out_t         out_data_o
);
  import swm_pkg::*;

  swm_cmd_t cmd;
  swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous sample still in work");

  // a new result only appears out of a sample in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a sample in work");

  // never overwrite a result that is still waiting
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

endmodule

// File: tb/tb_sliding_window_max.sv
`timescale 1ns / 100ps

module tb_sliding_window_max;
  import swm_pkg::*;

  localparam int          RING_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned RAND_BEATS  = 1800;
  localparam int unsigned SETTLE      = 24;

  typedef enum int unsigned {
    SRC_WIDE,
    SRC_NARROW,
    SRC_FALLING,
    SRC_RISING,
    SRC_EDGES
  } sample_src_e;

  class max_tracker;
    logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] run_max;
    int unsigned                wr_ptr;
    int unsigned                filled;
    int unsigned                win_raw;
    bit                         full;
    swm_out_t                   expected_max [$];
    int unsigned                errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      run_max = '0;
      win_raw = 3;
      errors  = 0;
      clear_window();
    endfunction

    function void clear_window();
      wr_ptr = 0;
      filled = 0;
      full   = 1'b0;
    endfunction

    function void set_window(logic [CFG_W-1:0] raw);
      win_raw = raw;
      clear_window();
    endfunction

    // zero acts as one, oversize saturates
    function int unsigned span();
      if (win_raw == 0) return 1;
      if (win_raw > RING_DEPTH) return RING_DEPTH;
      return win_raw;
    endfunction

    function logic signed [SAMPLE_W-1:0] scan(int unsigned k);
      logic signed [SAMPLE_W-1:0] m;
      m = ring[0];
      for (int unsigned i = 1; i < k; i++) begin
        if (ring[i] > m) m = ring[i];
      end
      return m;
    endfunction

    function void take_sample(swm_in_t beat);
      int unsigned                k;
      int unsigned                wp;
      logic signed [SAMPLE_W-1:0] leaving;
      bit                         produced;
      swm_out_t                   res;
      k = span();
      wp = (wr_ptr < k) ? wr_ptr : 0;
      produced = 1'b0;
      if (!full) begin
        ring[wp] = beat.sample;
        wp = (wp + 1 >= k) ? 0 : wp + 1;
        filled++;
        if (filled >= k) begin
          filled   = k;
          run_max  = scan(k);
          full     = 1'b1;
          produced = 1'b1;
        end
      end else begin
        leaving  = ring[wp];
        ring[wp] = beat.sample;
        wp = (wp + 1 >= k) ? 0 : wp + 1;
        if (leaving < run_max) begin
          if (beat.sample > run_max) run_max = beat.sample;
        end else begin
          run_max = scan(k);
        end
        produced = 1'b1;
      end
      wr_ptr = wp;
      if (produced) begin
        res.window_max = run_max;
        res.max_last   = beat.seq_last;
        expected_max.push_back(res);
      end
      if (beat.seq_last) clear_window();
    endfunction

    function void check_max(swm_out_t got);
      swm_out_t want;
      if (expected_max.size() == 0) begin
        $display("%0t: window_max expected none, actual %0d (max_last %0b)",
                 $time, got.window_max, got.max_last);
        errors++;
        return;
      end
      want = expected_max.pop_front();
      if (got.window_max !== want.window_max) begin
        $display("%0t: window_max expected %0d, actual %0d",
                 $time, want.window_max, got.window_max);
        errors++;
      end
      if (got.max_last !== want.max_last) begin
        $display("%0t: max_last expected %0b, actual %0b",
                 $time, want.max_last, got.max_last);
        errors++;
      end
    endfunction

    function int unsigned waiting();
      return expected_max.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  swm_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  swm_out_t          out_data_o;

  max_tracker  board = new();
  int unsigned in_gap;
  int unsigned in_idle_max;
  int unsigned out_idle_max;
  int unsigned beats_sent;
  int unsigned cycle_count;

  sliding_window_max dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one sample beat; returns at the falling edge after acceptance
  task automatic send_beat(input logic signed [SAMPLE_W-1:0] value, input logic last);
    swm_in_t beat;
    beat.sample   = value;
    beat.seq_last = last;
    if (!in_valid_i && in_gap > 0) repeat (in_gap) @(negedge clk_i);
    in_data_i  = beat;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.take_sample(beat);
    beats_sent++;
    @(negedge clk_i);
    in_gap = $urandom_range(0, in_idle_max);
    if (in_gap > 0) in_valid_i = 1'b0;
  endtask

  task automatic hold_off();
    in_valid_i = 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    @(negedge clk_i);
    in_gap = 0;
  endtask

  task automatic write_window(input logic [CFG_W-1:0] raw);
    in_valid_i = 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    // a beat that gives no result may still be in work
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = raw;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.set_window(raw);
    in_gap = 0;
  endtask

  task automatic send_sequence(input int unsigned k);
    int unsigned                len;
    int unsigned                step;
    sample_src_e                src;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] v;
    if ($urandom_range(0, 99) < 85) len = k + $urandom_range(0, 3 * k + 4);
    else len = $urandom_range(1, k);
    src  = sample_src_e'($urandom_range(0, 4));
    base = $urandom;
    step = $urandom_range(0, 5000);
    for (int unsigned i = 0; i < len; i++) begin
      case (src)
        SRC_WIDE: begin
          v = $urandom;
        end
        SRC_NARROW: begin
          v = int'($urandom_range(0, 8)) - 4;
        end
        SRC_FALLING: begin
          v = base - i * step;
        end
        SRC_RISING: begin
          v = base + i * step;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: v = 32'sh7fff_ffff;
            1: v = 32'sh8000_0000;
            2: v = 32'sh0000_0000;
            3: v = -32'sd1;
            default: v = 32'sd1;
          endcase
        end
      endcase
      send_beat(v, i == len - 1);
    end
    if ($urandom_range(0, 29) == 0) hold_off();
  endtask

  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      hold = $urandom_range(0, out_idle_max);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_max(out_data_o);
    end
  end

  initial begin
    int unsigned phase;
    int unsigned raw;
    int unsigned k;
    int unsigned goal;
    int unsigned rand_start;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    in_gap       = 0;
    in_idle_max  = 19;
    out_idle_max = 19;
    beats_sent   = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default window of three: extremes, tie with the leaving sample
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh0000_0000, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sh8000_0000, 1'b1);
    // sequence shorter than the window
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd6, 1'b1);
    // equal samples force a rescan on every beat from the one that fills the window
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd4, 1'b1);
    // partial window dropped by a register write
    send_beat(32'sd1, 1'b0);
    send_beat(32'sd2, 1'b0);
    write_window(5'd1);
    send_beat(32'sd10, 1'b0);
    send_beat(-32'sd3, 1'b1);
    write_window(5'd0);
    send_beat(32'sd8, 1'b0);
    send_beat(32'sd9, 1'b1);

    rand_start = beats_sent;
    phase = 0;
    while (beats_sent - rand_start < RAND_BEATS) begin
      case (phase)
        0: raw = 31;
        1: raw = 16;
        2: raw = 17;
        default: begin
          case ($urandom_range(0, 19))
            0, 1, 2:    raw = $urandom_range(17, 31);
            3, 4, 5, 6: raw = $urandom_range(6, 16);
            default:    raw = $urandom_range(0, 5);
          endcase
        end
      endcase
      case ($urandom_range(0, 3))
        0: in_idle_max = 0;
        1: in_idle_max = 3;
        default: in_idle_max = 19;
      endcase
      case ($urandom_range(0, 3))
        0: out_idle_max = 0;
        1: out_idle_max = 3;
        default: out_idle_max = 19;
      endcase
      write_window(raw[CFG_W-1:0]);
      k = (raw == 0) ? 1 : (raw > RING_DEPTH) ? RING_DEPTH : raw;
      goal = beats_sent + $urandom_range(60, 150);
      while (beats_sent < goal) send_sequence(k);
      phase++;
    end

    in_valid_i = 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (SETTLE + 6) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
